// File: rtl/core/stbs_pkg.sv
`default_nettype none

package stbs_pkg;

    localparam int DEF_TABLE_DEPTH = 1024;

    localparam int CNT_W     = 11;
    localparam int IDX_W     = 10;
    localparam int VAL_W     = 32;
    localparam int POS_W     = 10;
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 16;

    localparam int VALUE_LSB = IDX_W;
    localparam int KEY_LSB   = IDX_W + VAL_W;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_PROBE = 4'b0010,
        ST_CMP   = 4'b0100,
        ST_FIN   = 4'b1000
    } state_t;

    typedef struct packed {
        logic load;
        logic wr;
        logic probe;
        logic cmp;
        logic fin;
    } cmd_t;

    typedef struct packed {
        logic live;
        logic hit;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// File: rtl/core/stbs_ctrl.sv
`default_nettype none

module stbs_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    input  wire logic             s_tuser,
    output logic                  s_tready,
    input  wire stbs_pkg::status_t st,
    output stbs_pkg::cmd_t        cmd
);

    stbs_pkg::state_t state_reg;
    stbs_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= stbs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = (state_reg == stbs_pkg::ST_IDLE);
        case (state_reg)
            stbs_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == stbs_pkg::REQ_SEARCH) begin
                        cmd.load   = 1'b1;
                        state_next = stbs_pkg::ST_PROBE;
                    end else begin
                        cmd.wr = 1'b1;
                    end
                end
            end
            stbs_pkg::ST_PROBE: begin
                if (st.live) begin
                    cmd.probe  = 1'b1;
                    state_next = stbs_pkg::ST_CMP;
                end else begin
                    state_next = stbs_pkg::ST_FIN;
                end
            end
            stbs_pkg::ST_CMP: begin
                cmd.cmp    = 1'b1;
                state_next = st.hit ? stbs_pkg::ST_FIN : stbs_pkg::ST_PROBE;
            end
            stbs_pkg::ST_FIN: begin
                if (st.out_free) begin
                    cmd.fin    = 1'b1;
                    state_next = stbs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = stbs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/stbs_dp.sv
`default_nettype none

module stbs_dp #(
    parameter int TABLE_DEPTH = stbs_pkg::DEF_TABLE_DEPTH
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic [stbs_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                           cfg_valid,
    input  wire logic [stbs_pkg::CNT_W-1:0]     cfg_data,
    input  wire stbs_pkg::cmd_t                 cmd,
    output stbs_pkg::status_t                   st,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [stbs_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tuser
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [stbs_pkg::VAL_W-1:0] mem [TABLE_DEPTH];

    logic [stbs_pkg::CNT_W-1:0] count_reg;
    logic [stbs_pkg::CNT_W-1:0] lo_reg;
    logic [stbs_pkg::CNT_W-1:0] hi1_reg;
    logic [stbs_pkg::CNT_W-1:0] mid_reg;
    logic [stbs_pkg::VAL_W-1:0] key_reg;
    logic [stbs_pkg::VAL_W-1:0] rdata_reg;
    logic                       found_reg;
    logic [stbs_pkg::POS_W-1:0] pos_reg;
    logic                       m_valid_reg;
    logic                       m_found_reg;
    logic [stbs_pkg::POS_W-1:0] m_pos_reg;

    logic [stbs_pkg::CNT_W-1:0] n_sat;
    logic [stbs_pkg::CNT_W:0]   mid_sum;
    logic [stbs_pkg::CNT_W-1:0] mid;
    logic [stbs_pkg::IDX_W-1:0] wr_idx;
    logic [stbs_pkg::VAL_W-1:0] wr_val;
    logic                       wr_ok;
    logic                       eq;
    logic                       less;

    assign wr_idx = s_tdata[stbs_pkg::IDX_W-1:0];
    assign wr_val = s_tdata[stbs_pkg::VALUE_LSB +: stbs_pkg::VAL_W];
    assign wr_ok  = (32'(wr_idx) < 32'(TABLE_DEPTH));

    assign n_sat   = (32'(count_reg) > 32'(TABLE_DEPTH)) ?
                     stbs_pkg::CNT_W'(TABLE_DEPTH) : count_reg;
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi1_reg} - {{stbs_pkg::CNT_W{1'b0}}, 1'b1};
    assign mid     = mid_sum[stbs_pkg::CNT_W:1];

    assign eq   = (rdata_reg == key_reg);
    assign less = ($signed(rdata_reg) < $signed(key_reg));

    assign st.live     = (lo_reg < hi1_reg);
    assign st.hit      = eq;
    assign st.out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (cmd.wr && wr_ok) begin
            mem[AW'(wr_idx)] <= wr_val;
        end
        if (cmd.probe) begin
            rdata_reg <= mem[AW'(mid)];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cfg_valid) begin
            count_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            lo_reg    <= '0;
            hi1_reg   <= n_sat;
            key_reg   <= s_tdata[stbs_pkg::KEY_LSB +: stbs_pkg::VAL_W];
            found_reg <= 1'b0;
            pos_reg   <= '0;
        end
        if (cmd.probe) begin
            mid_reg <= mid;
        end
        if (cmd.cmp) begin
            if (eq) begin
                found_reg <= 1'b1;
                pos_reg   <= mid_reg[stbs_pkg::POS_W-1:0];
            end else if (less) begin
                lo_reg <= mid_reg + stbs_pkg::CNT_W'(1);
            end else begin
                hi1_reg <= mid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.fin) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fin) begin
            m_found_reg <= found_reg;
            m_pos_reg   <= pos_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = {{(stbs_pkg::M_TDATA_W - stbs_pkg::POS_W){1'b0}}, m_pos_reg};

endmodule

`default_nettype wire

// File: rtl/core/sorted_table_binary_search.sv
// Binary search over a table of signed 32-bit entries held in on-chip memory.
// A write transfer (tuser 0) stores one entry; indexes at or
// beyond TABLE_DEPTH are dropped. A search transfer (tuser 1) probes entries
// 0 .. entry_count-1 (count saturated at TABLE_DEPTH) and returns found on
// m_tuser and the matching position on m_tdata, position 0 when not found.
// Each probe is a registered read on the single memory read port followed by
// a compare and narrow step; a search makes at most floor(log2(n)) + 1
// probes. s_tready is high only while no search is in flight; a finished
// result sits in an output register, so the next item is taken while it
// waits for m_tready. Table contents are undefined until written. Write
// entry_count only while idle.
`default_nettype none

module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = stbs_pkg::DEF_TABLE_DEPTH
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // s_tdata: entry_index[9:0], entry_value[41:10], search_key[73:42], zero pad
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [stbs_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: req_type[0]
    input  wire logic                           s_tuser,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [stbs_pkg::CNT_W-1:0]     cfg_data,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // m_tdata: position[9:0], zero pad
    output logic [stbs_pkg::M_TDATA_W-1:0]      m_tdata,
    // m_tuser: found[0]
    output logic                                m_tuser
);

    stbs_pkg::cmd_t    cmd;
    stbs_pkg::status_t st;

    assign cfg_ready = 1'b1;

    stbs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    stbs_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .st        (st),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

// File: rtl/core/stbs_chk.sv
`default_nettype none

module stbs_chk (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           s_tuser,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [stbs_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                           m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped before transfer");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("miss with nonzero position");

    a_write_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == stbs_pkg::REQ_WRITE) && !m_tvalid |=> !m_tvalid)
        else $error("write produced a result");

    a_search_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == stbs_pkg::REQ_SEARCH) |=> !s_tready)
        else $error("input taken during search");

endmodule

bind sorted_table_binary_search stbs_chk u_stbs_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// File: tb/sv/sorted_table_binary_search_tb.sv
`timescale 1ns / 1ps

module sorted_table_binary_search_tb;

    localparam int DEPTH         = stbs_pkg::DEF_TABLE_DEPTH;
    localparam int SETTLE_CYCLES = 30;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct packed {
        logic                       hit;
        logic [stbs_pkg::POS_W-1:0] pos;
    } lookup_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [stbs_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                           s_tuser = stbs_pkg::REQ_WRITE;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [stbs_pkg::CNT_W-1:0]     cfg_data = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [stbs_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           m_tuser;

    logic [stbs_pkg::VAL_W-1:0] stored_entries [DEPTH];
    logic [stbs_pkg::CNT_W-1:0] count_q = '0;
    lookup_t                    pending_lookups [$];
    int                         err_count = 0;
    int                         cycle_count = 0;
    int                         idle_pct = 0;
    int                         stall_left = 0;

    sorted_table_binary_search #(
        .TABLE_DEPTH(DEPTH)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("sorted_table_binary_search_tb: done, errors");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic lookup_t search_entries(input logic [stbs_pkg::VAL_W-1:0] key);
        lookup_t ans;
        int      n;
        int      lo;
        int      hi;
        int      mid;
        ans = '0;
        n = (count_q > DEPTH) ? DEPTH : int'(count_q);
        lo = 0;
        hi = n - 1;
        while (lo <= hi && !ans.hit) begin
            mid = (lo + hi) / 2;
            if (stored_entries[mid] == key) begin
                ans.hit = 1'b1;
                ans.pos = mid[stbs_pkg::POS_W-1:0];
            end else if ($signed(stored_entries[mid]) < $signed(key)) begin
                lo = mid + 1;
            end else begin
                hi = mid - 1;
            end
        end
        return ans;
    endfunction

    always @(posedge aclk) begin : check_results
        lookup_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_lookups.size() == 0) begin
                report_mismatch($sformatf("result with no search pending: found=%0b pos=%0d",
                                          m_tuser, m_tdata[stbs_pkg::POS_W-1:0]));
            end else begin
                want = pending_lookups.pop_front();
                if (m_tuser !== want.hit)
                    report_mismatch($sformatf("found: got %0b, want %0b", m_tuser, want.hit));
                if (m_tdata[stbs_pkg::POS_W-1:0] !== want.pos)
                    report_mismatch($sformatf("position: got %0d, want %0d",
                                              m_tdata[stbs_pkg::POS_W-1:0], want.pos));
            end
        end
    end

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
            stall_left <= $urandom_range(0, 9);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_item(input logic kind, input logic [stbs_pkg::IDX_W-1:0] idx,
                             input logic [stbs_pkg::VAL_W-1:0] val,
                             input logic [stbs_pkg::VAL_W-1:0] key);
        logic [stbs_pkg::S_TDATA_W-1:0] data;
        int                             gap;
        data = '0;
        data[stbs_pkg::IDX_W-1:0] = idx;
        data[stbs_pkg::VALUE_LSB +: stbs_pkg::VAL_W] = val;
        data[stbs_pkg::KEY_LSB +: stbs_pkg::VAL_W] = key;
        if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
            gap = $urandom_range(1, 10);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        if (kind == stbs_pkg::REQ_WRITE)
            stored_entries[idx] = val;
        else
            pending_lookups.push_back(search_entries(key));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_entry_count(input logic [stbs_pkg::CNT_W-1:0] n);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= n;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        count_q = n;
    endtask

    task automatic load_sorted(input int n, input longint base, input int unsigned step_max);
        longint v;
        v = base;
        for (int i = 0; i < n; i++) begin
            if (v > 64'sd2147483647)
                v = 64'sd2147483647;
            send_item(stbs_pkg::REQ_WRITE, i[stbs_pkg::IDX_W-1:0], v[stbs_pkg::VAL_W-1:0],
                      $urandom);
            v += $urandom_range(0, step_max);
        end
    endtask

    // mostly keys that sit in the table, some neighbors, some anything, and some writes beyond the count
    task automatic run_searches(input int k);
        int                         n;
        int                         pick;
        logic [stbs_pkg::VAL_W-1:0] key;
        n = (count_q > DEPTH) ? DEPTH : int'(count_q);
        for (int i = 0; i < k; i++) begin
            pick = $urandom_range(0, 99);
            if (n < DEPTH && pick < 8) begin
                send_item(stbs_pkg::REQ_WRITE,
                          stbs_pkg::IDX_W'($urandom_range(n, DEPTH - 1)), $urandom, $urandom);
                continue;
            end
            if (n == 0 || pick >= 80)
                key = $urandom;
            else if (pick >= 60)
                key = stored_entries[$urandom_range(0, n - 1)] + ($urandom_range(0, 1) ? 1 : -1);
            else
                key = stored_entries[$urandom_range(0, n - 1)];
            send_item(stbs_pkg::REQ_SEARCH, stbs_pkg::IDX_W'($urandom), $urandom, key);
        end
    endtask

    task automatic test_empty_table();
        write_entry_count('0);
        send_item(stbs_pkg::REQ_SEARCH, '0, '0, 32'h8000_0000);
        send_item(stbs_pkg::REQ_SEARCH, '1, '1, 32'h7FFF_FFFF);
        send_item(stbs_pkg::REQ_SEARCH, '0, '0, 32'h0000_0000);
    endtask

    task automatic test_directed_cases();
        logic [stbs_pkg::VAL_W-1:0] vals [8];
        vals = '{32'h8000_0000, -32'sd1000, 32'hFFFF_FFFF, 32'd0,
                 32'd1, 32'd77, 32'd1000, 32'h7FFF_FFFF};
        for (int i = 0; i < 8; i++)
            send_item(stbs_pkg::REQ_WRITE, i[stbs_pkg::IDX_W-1:0], vals[i], '0);
        write_entry_count(stbs_pkg::CNT_W'(8));
        send_item(stbs_pkg::REQ_SEARCH, '0, '0, 32'h8000_0000);
        send_item(stbs_pkg::REQ_SEARCH, '0, '0, 32'h7FFF_FFFF);
        send_item(stbs_pkg::REQ_SEARCH, '0, '0, 32'd0);
        send_item(stbs_pkg::REQ_SEARCH, '0, '0, 32'd77);
        send_item(stbs_pkg::REQ_SEARCH, '0, '0, -32'sd2);
        send_item(stbs_pkg::REQ_SEARCH, '0, '0, 32'd2);
        send_item(stbs_pkg::REQ_SEARCH, '0, '0, 32'd1001);
        write_entry_count(stbs_pkg::CNT_W'(1));
        send_item(stbs_pkg::REQ_SEARCH, '0, '0, 32'h8000_0000);
        send_item(stbs_pkg::REQ_SEARCH, '0, '0, 32'd5);
        // break the ordering: the DUT and the model still probe the same entries
        send_item(stbs_pkg::REQ_WRITE, stbs_pkg::IDX_W'(3), 32'h7FFF_FFFF, '0);
        write_entry_count(stbs_pkg::CNT_W'(8));
        send_item(stbs_pkg::REQ_SEARCH, '0, '0, 32'h7FFF_FFFF);
        send_item(stbs_pkg::REQ_SEARCH, '0, '0, 32'd0);
    endtask

    task automatic test_full_table();
        idle_pct = 15;
        load_sorted(DEPTH, -64'sd2147483648, 8388607);
        write_entry_count(stbs_pkg::CNT_W'(DEPTH));
        run_searches(15);
        write_entry_count('1);
        run_searches(15);
        write_entry_count(stbs_pkg::CNT_W'(DEPTH - 1));
        run_searches(15);
    endtask

    task automatic test_random_phases();
        logic signed [stbs_pkg::VAL_W-1:0] r;
        longint                            base;
        int                                n;
        int                                sel;
        for (int ph = 0; ph < 14; ph++) begin
            if (ph >= 11)
                idle_pct = 0;
            else
                idle_pct = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 15 : 40);
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                write_entry_count('0);
            end else if (sel == 1) begin
                case ($urandom_range(0, 2))
                    0: n = DEPTH;
                    1: n = 2047;
                    default: n = $urandom_range(25, 2047);
                endcase
                write_entry_count(stbs_pkg::CNT_W'(n));
            end else begin
                n = $urandom_range(1, 24);
                r = $urandom;
                base = longint'(r) / 2;
                load_sorted(n, base, $urandom_range(0, 1) ? 3 : 200000000);
                write_entry_count(stbs_pkg::CNT_W'(n));
            end
            run_searches(22);
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_table();
        test_directed_cases();
        test_full_table();
        test_random_phases();
        drain_results();
        if (pending_lookups.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_lookups.size()));
        if (err_count == 0) begin
            $display("sorted_table_binary_search_tb: done, clean");
        end else begin
            $display("sorted_table_binary_search_tb: done, errors");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/stbs_pkg.sv
rtl/core/stbs_ctrl.sv
rtl/core/stbs_dp.sv
rtl/core/sorted_table_binary_search.sv
rtl/core/stbs_chk.sv
tb/sv/sorted_table_binary_search_tb.sv
